>>> sv/yuv420_to_rgb_line_converter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the YUV 4:2:0 to RGB line converter
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef YUV420_TO_RGB_LINE_CONVERTER_MACROS_SVH
`define YUV420_TO_RGB_LINE_CONVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Y2R_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define Y2R_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/y2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared widths, coefficients, types and helper functions of the converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int STORE_DEPTH    = MAX_LINE_WIDTH / 2;
    localparam int SLOT_W         = $clog2(STORE_DEPTH);
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int WIDTH_W        = 13;
    localparam int PAIR_W         = 16;
    localparam int PROD_W         = 28;

    localparam logic [WIDTH_W-1:0] RESET_LAST_COL = 13'd639;

    localparam int K_LUMA   = 76283;
    localparam int K_C2_B0  = 132252;
    localparam int K_C1_B1  = 53281;
    localparam int K_C2_B1  = 25625;
    localparam int K_C1_B2  = 104595;
    localparam int LUMA_OFS = 16;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       last;
    } y2r_pixel_t;

    // Last column index of a line for a given register value.
    function automatic logic [WIDTH_W-1:0] last_column(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] w;
        begin
            if (v < WIDTH_W'(2))
            begin
                w = WIDTH_W'(2);
            end
            else if (v > WIDTH_W'(MAX_LINE_WIDTH))
            begin
                w = WIDTH_W'(MAX_LINE_WIDTH);
            end
            else
            begin
                w = {v[WIDTH_W-1:1], 1'b0};
            end
            last_column = w - WIDTH_W'(1);
        end
    endfunction

    // Floor shift by 16 and saturate to one byte.
    function automatic logic [7:0] shift_clamp(input logic signed [PROD_W-1:0] s);
        logic [PROD_W-17:0] sh;
        begin
            sh = s[PROD_W-1:16];
            if (sh[PROD_W-17])
            begin
                shift_clamp = 8'd0;
            end
            else if (sh[PROD_W-18:8] != '0)
            begin
                shift_clamp = 8'd255;
            end
            else
            begin
                shift_clamp = sh[7:0];
            end
        end
    endfunction

endpackage

>>> sv/y2r_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pix_if
// Input pixel channel: one luma byte and two chroma bytes per item.
// ----------------------------------------------------------------------------
interface y2r_pix_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] luma;
    logic [7:0] first_chroma;
    logic [7:0] second_chroma;

    modport source (output valid, output frame_start, output luma,
                    output first_chroma, output second_chroma, input ready);
    modport sink   (input valid, input frame_start, input luma,
                    input first_chroma, input second_chroma, output ready);
endinterface

// ----------------------------------------------------------------------------
// y2r_rgb_if
// Output channel: three color bytes and the end-of-line flag per item.
// ----------------------------------------------------------------------------
interface y2r_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic       line_end;

    modport source (output valid, output out_byte0, output out_byte1,
                    output out_byte2, output line_end, input ready);
    modport sink   (input valid, input out_byte0, input out_byte1,
                    input out_byte2, input line_end, output ready);
endinterface

// ----------------------------------------------------------------------------
// y2r_cfg_if
// Configuration write channel carrying the line width register.
// ----------------------------------------------------------------------------
interface y2r_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [y2r_pkg::WIDTH_W-1:0]     line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

>>> sv/yuv420_to_rgb_line_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_rgb_line_converter
// Raster-order YUV 4:2:0 to RGB conversion with a chroma line store.
// ----------------------------------------------------------------------------
// One pixel item is accepted every clock cycle while the first stage can
// advance, and each yields one result item after the chroma line store read,
// the coefficient multiplies and the sum, shift and clamp into the output
// register. Backpressure on the result channel stalls only the stages
// that are full, so input is still taken while bubbles remain. The chroma
// store needs no clearing after reset; line_width may be written only while
// no items are in flight.
module yuv420_to_rgb_line_converter (
    input  logic       clk,
    input  logic       rst_n,
    y2r_cfg_if.sink    cfg,
    y2r_pix_if.sink    pix,
    y2r_rgb_if.source  rgb
);

    localparam int COL_W   = y2r_pkg::COL_W;
    localparam int SLOT_W  = y2r_pkg::SLOT_W;
    localparam int WIDTH_W = y2r_pkg::WIDTH_W;
    localparam int PAIR_W  = y2r_pkg::PAIR_W;

    logic [WIDTH_W-1:0] last_col_reg, last_col_next;
    logic [COL_W-1:0]   col_reg, col_next, col;
    logic               odd_reg, odd_next, odd;
    logic [PAIR_W-1:0]  held_reg, held_next, pair_in;
    logic               accept, store_wr, store_rd, last;
    logic [SLOT_W-1:0]  slot;
    logic [PAIR_W-1:0]  store_rdata, pair_s1;

    logic               s1v_reg, s1v_next;
    logic [7:0]         luma_s1_reg;
    logic [PAIR_W-1:0]  pair_s1_reg;
    logic               from_store_s1_reg;
    logic               last_s1_reg;
    logic               color_ready;
    logic               en1;
    y2r_pkg::y2r_pixel_t px_s1;

    assign cfg.ready = 1'b1;
    assign en1       = !s1v_reg || color_ready;
    assign pix.ready = en1;
    assign accept    = pix.valid && en1;

    assign col      = pix.frame_start ? '0 : col_reg;
    assign odd      = pix.frame_start ? 1'b0 : odd_reg;
    assign slot     = col[COL_W-1:1];
    assign store_rd = odd;
    assign store_wr = !odd && !col[0];
    assign pair_in  = store_wr ? {pix.second_chroma, pix.first_chroma} : held_reg;
    assign last     = {1'b0, col} >= last_col_reg;

    always_comb
    begin
        last_col_next = last_col_reg;
        col_next      = col_reg;
        odd_next      = odd_reg;
        held_next     = held_reg;
        if (cfg.valid)
        begin
            last_col_next = y2r_pkg::last_column(cfg.line_width);
        end
        if (accept)
        begin
            col_next  = last ? '0 : col + COL_W'(1);
            odd_next  = odd ^ last;
            held_next = pair_in;
        end
    end

    assign s1v_next = en1 ? pix.valid : s1v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= y2r_pkg::RESET_LAST_COL;
            col_reg      <= '0;
            odd_reg      <= 1'b0;
            held_reg     <= '0;
            s1v_reg      <= 1'b0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            col_reg      <= col_next;
            odd_reg      <= odd_next;
            held_reg     <= held_next;
            s1v_reg      <= s1v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            luma_s1_reg       <= pix.luma;
            pair_s1_reg       <= pair_in;
            from_store_s1_reg <= store_rd;
            last_s1_reg       <= last;
        end
    end

    y2r_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (y2r_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && store_wr),
        .waddr (slot),
        .wdata (pair_in),
        .re    (accept && store_rd),
        .raddr (slot),
        .rdata (store_rdata)
    );

    assign pair_s1    = from_store_s1_reg ? store_rdata : pair_s1_reg;
    assign px_s1.luma = luma_s1_reg;
    assign px_s1.c1   = pair_s1[7:0];
    assign px_s1.c2   = pair_s1[15:8];
    assign px_s1.last = last_s1_reg;

    y2r_color u_color (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1v_reg),
        .in_ready (color_ready),
        .px       (px_s1),
        .rgb      (rgb)
    );

endmodule

>>> sv/y2r_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module y2r_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/y2r_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_color
// Two-stage color matrix: registered products, then sum, shift and clamp
// into the output register.
// ----------------------------------------------------------------------------
module y2r_color (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  y2r_pkg::y2r_pixel_t px,
    y2r_rgb_if.source           rgb
);

    localparam int PW = y2r_pkg::PROD_W;

    logic signed [PW-1:0] yd, c1d, c2d;
    logic signed [PW-1:0] p_y_reg, p_b0_reg, p_b1a_reg, p_b1b_reg, p_b2_reg;
    logic signed [PW-1:0] sum0, sum1, sum2;
    logic                 last_a_reg;
    logic                 va_reg, va_next;
    logic                 ov_reg, ov_next;
    logic [7:0]           b0_reg, b1_reg, b2_reg;
    logic                 le_reg;
    logic                 en_a, en_b;

    assign en_b     = !ov_reg || rgb.ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    assign yd  = PW'($signed({1'b0, px.luma})) - PW'(y2r_pkg::LUMA_OFS);
    assign c1d = PW'($signed({~px.c1[7], px.c1[6:0]}));
    assign c2d = PW'($signed({~px.c2[7], px.c2[6:0]}));

    assign sum0 = p_y_reg + p_b0_reg;
    assign sum1 = p_y_reg - p_b1a_reg - p_b1b_reg;
    assign sum2 = p_y_reg + p_b2_reg;

    assign va_next = en_a ? in_valid : va_reg;
    assign ov_next = en_b ? va_reg : ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            p_y_reg    <= yd * PW'(y2r_pkg::K_LUMA);
            p_b0_reg   <= c2d * PW'(y2r_pkg::K_C2_B0);
            p_b1a_reg  <= c1d * PW'(y2r_pkg::K_C1_B1);
            p_b1b_reg  <= c2d * PW'(y2r_pkg::K_C2_B1);
            p_b2_reg   <= c1d * PW'(y2r_pkg::K_C1_B2);
            last_a_reg <= px.last;
        end
        if (en_b)
        begin
            b0_reg <= y2r_pkg::shift_clamp(sum0);
            b1_reg <= y2r_pkg::shift_clamp(sum1);
            b2_reg <= y2r_pkg::shift_clamp(sum2);
            le_reg <= last_a_reg;
        end
    end

    assign rgb.valid     = ov_reg;
    assign rgb.out_byte0 = b0_reg;
    assign rgb.out_byte1 = b1_reg;
    assign rgb.out_byte2 = b2_reg;
    assign rgb.line_end  = le_reg;

endmodule

>>> sv/y2r_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "yuv420_to_rgb_line_converter_macros.svh"

module y2r_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_ready,
    input logic       rgb_valid,
    input logic       rgb_ready,
    input logic [7:0] rgb_byte0,
    input logic [7:0] rgb_byte1,
    input logic [7:0] rgb_byte2,
    input logic       rgb_line_end
);

    logic [2:0]  pending_reg, pending_next;
    logic        in_acc, out_acc;
    logic        out_stall;
    logic [24:0] rgb_word;

    assign in_acc    = pix_valid && pix_ready;
    assign out_acc   = rgb_valid && rgb_ready;
    assign out_stall = rgb_valid && !rgb_ready;
    assign rgb_word  = {rgb_byte0, rgb_byte1, rgb_byte2, rgb_line_end};

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result keeps its bytes until it is taken.
    `Y2R_ASSERT_NEXT(a_out_hold, out_stall, rgb_valid && $stable(rgb_word), "held result changed")

    // No result item appears without an accepted pixel behind it.
    `Y2R_ASSERT_SAME(a_no_orphan, pending_reg == 3'd0, !rgb_valid, "result without pixel")

    // At most three pixels are in flight.
    `Y2R_ASSERT_SAME(a_depth, 1'b1, pending_reg <= 3'd3, "too many items in flight")

    // A ready result side never blocks the pixel side.
    `Y2R_ASSERT_SAME(a_flow, rgb_ready, pix_ready, "input stalled while output ready")

endmodule

bind yuv420_to_rgb_line_converter y2r_checker u_y2r_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_valid    (pix.valid),
    .pix_ready    (pix.ready),
    .rgb_valid    (rgb.valid),
    .rgb_ready    (rgb.ready),
    .rgb_byte0    (rgb.out_byte0),
    .rgb_byte1    (rgb.out_byte1),
    .rgb_byte2    (rgb.out_byte2),
    .rgb_line_end (rgb.line_end)
);
